### hw/rtl/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types, codes and pixel conversions of the rectangle blit engine.
// ----------------------------------------------------------------------------
package rbe_pkg;

   localparam logic [1:0] OP_START     = 2'd0;
   localparam logic [1:0] OP_ADVANCE   = 2'd1;
   localparam logic [1:0] OP_READ_DATA = 2'd2;

   localparam logic [1:0] MODE_FILL = 2'd0;
   localparam logic [1:0] MODE_S2H  = 2'd1;
   localparam logic [1:0] MODE_H2S  = 2'd2;
   localparam logic [1:0] MODE_S2S  = 2'd3;

   localparam logic REGION_FB   = 1'b0;
   localparam logic REGION_HOST = 1'b1;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLIT_MODE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_ORIGIN = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_ORIGIN   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXTENT        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOST_PITCH    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_COLOR    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 3'd6;

   localparam logic [15:0] SCREEN_WIDTH_RESET = 16'd640;

   typedef struct packed {
      logic [1:0]  blit_mode;
      logic [31:0] source_origin;
      logic [31:0] dest_origin;
      logic [31:0] extent;
      logic [19:0] host_pitch;
      logic [31:0] fill_color;
      logic [15:0] screen_width;
   } cfg_type;

   typedef struct packed {
      logic        region;
      logic        is_write;
      logic        last;
      logic [31:0] write_data;
   } desc_ctl_type;

   typedef struct packed {
      logic        target_region;
      logic [31:0] byte_offset;
      logic        is_write;
      logic [31:0] write_data;
      logic        last_request;
   } rsp_type;

   function automatic logic [31:0] to_bgrx(input logic [15:0] p);
      return {8'h00, p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
   endfunction

   function automatic logic [31:0] to_565(input logic [31:0] p);
      return {16'h0000, p[23:19], p[15:10], p[7:3]};
   endfunction

endpackage

### hw/rtl/rbe_queue.sv
// ----------------------------------------------------------------------------
// rbe_queue
// Small register FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rbe_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                wr_en;
   logic                rd_en;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_BITS'(wr_en) - CNT_BITS'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/rbe_front.sv
// ----------------------------------------------------------------------------
// rbe_front
// Blit sequencer: decodes transactions, walks the rectangle and emits one
// request descriptor per issuing advance.
// ----------------------------------------------------------------------------
module rbe_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rbe_pkg::cfg_type      cfg,
   input  logic                  accept,
   input  logic [1:0]            operation,
   input  logic [31:0]           read_data,
   output logic                  desc_valid,
   output rbe_pkg::desc_ctl_type desc_ctl,
   output logic [COORD_BITS:0]   desc_x,
   output logic [COORD_BITS:0]   desc_y
);
   import rbe_pkg::*;

   localparam int C = COORD_BITS;

   logic         busy_ff, busy_in;
   logic         awaiting_ff, awaiting_in;
   logic         ready_ff, ready_in;
   logic [31:0]  latch_ff, latch_in;
   logic [C-1:0] row_ff, row_in;
   logic [C-1:0] col_ff, col_in;

   logic [C-1:0] w, h, sx, sy, dx, dy;
   logic [C-1:0] roff, coff, col_next, row_next;
   logic [C:0]   srx, sry, drx, dry;
   logic [1:0]   mode;

   assign mode = cfg.blit_mode;
   assign w    = cfg.extent[C-1:0];
   assign h    = cfg.extent[16 +: C];
   assign sx   = cfg.source_origin[C-1:0];
   assign sy   = cfg.source_origin[16 +: C];
   assign dx   = cfg.dest_origin[C-1:0];
   assign dy   = cfg.dest_origin[16 +: C];

   // h + ~row is h - 1 - row
   assign roff = (mode != MODE_S2H && dy > sy) ? h + ~row_ff : row_ff;
   assign coff = (mode == MODE_S2S && dy == sy && dx > sx) ? w + ~col_ff : col_ff;

   assign srx = {1'b0, sx} + {1'b0, coff};
   assign sry = {1'b0, sy} + {1'b0, roff};
   assign drx = {1'b0, dx} + {1'b0, coff};
   assign dry = {1'b0, dy} + {1'b0, roff};

   assign col_next = col_ff + 1'b1;
   assign row_next = row_ff + 1'b1;

   always_comb begin
      busy_in     = busy_ff;
      awaiting_in = awaiting_ff;
      ready_in    = ready_ff;
      latch_in    = latch_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      desc_valid  = 1'b0;
      desc_ctl    = '0;
      desc_x      = '0;
      desc_y      = '0;
      if (accept) begin
         case (operation)
            OP_START: begin
               busy_in     = (w != '0) && (h != '0);
               awaiting_in = 1'b0;
               ready_in    = 1'b0;
               row_in      = '0;
               col_in      = '0;
            end
            OP_READ_DATA: begin
               if (busy_ff && awaiting_ff) begin
                  latch_in    = read_data;
                  awaiting_in = 1'b0;
                  ready_in    = 1'b1;
               end
            end
            OP_ADVANCE: begin
               if (busy_ff && !awaiting_ff) begin
                  if (row_ff >= h || col_ff >= w) begin
                     // extent shrank under a running blit
                     busy_in  = 1'b0;
                     ready_in = 1'b0;
                  end else begin
                     desc_valid = 1'b1;
                     if (mode != MODE_FILL && !ready_ff) begin
                        desc_ctl.region   = (mode == MODE_H2S) ? REGION_HOST : REGION_FB;
                        desc_ctl.is_write = 1'b0;
                        desc_x            = srx;
                        desc_y            = sry;
                        awaiting_in       = 1'b1;
                     end else begin
                        desc_ctl.is_write = 1'b1;
                        desc_x            = drx;
                        desc_y            = dry;
                        case (mode)
                           MODE_S2H: begin
                              desc_ctl.region     = REGION_HOST;
                              desc_ctl.write_data = to_bgrx(latch_ff[15:0]);
                           end
                           MODE_FILL: begin
                              desc_ctl.region     = REGION_FB;
                              desc_ctl.write_data = to_565(cfg.fill_color);
                           end
                           MODE_H2S: begin
                              desc_ctl.region     = REGION_FB;
                              desc_ctl.write_data = to_565(latch_ff);
                           end
                           default: begin
                              desc_ctl.region     = REGION_FB;
                              desc_ctl.write_data = {16'h0000, latch_ff[15:0]};
                           end
                        endcase
                        ready_in = 1'b0;
                        if (col_next >= w) begin
                           col_in = '0;
                           row_in = row_next;
                           if (row_next >= h) begin
                              busy_in       = 1'b0;
                              desc_ctl.last = 1'b1;
                           end
                        end else begin
                           col_in = col_next;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      latch_ff <= latch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         awaiting_ff <= 1'b0;
         ready_ff    <= 1'b0;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         busy_ff     <= busy_in;
         awaiting_ff <= awaiting_in;
         ready_ff    <= ready_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
      end
   end

`ifndef SYNTH
   last_is_write: assert property (@(posedge clock) disable iff (reset)
      desc_valid && desc_ctl.last |-> desc_ctl.is_write)
      else $error("last flag on a read request");

   read_sets_wait: assert property (@(posedge clock) disable iff (reset)
      desc_valid && !desc_ctl.is_write |=> awaiting_ff)
      else $error("read issued without waiting for data");

   last_ends_blit: assert property (@(posedge clock) disable iff (reset)
      desc_valid && desc_ctl.last |=> !busy_ff)
      else $error("blit still busy after last write");

   wait_needs_busy: assert property (@(posedge clock) disable iff (reset)
      awaiting_ff |-> busy_ff)
      else $error("waiting for read data while idle");
`endif

endmodule

### hw/rtl/rbe_back.sv
// ----------------------------------------------------------------------------
// rbe_back
// Address stage: multiplies row by pitch, adds column, and queues results.
// ----------------------------------------------------------------------------
module rbe_back #(
   parameter int COORD_BITS = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rbe_pkg::cfg_type      cfg,
   input  logic                  mid_empty,
   output logic                  mid_pop,
   input  rbe_pkg::desc_ctl_type mid_ctl,
   input  logic [COORD_BITS:0]   mid_x,
   input  logic [COORD_BITS:0]   mid_y,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output rbe_pkg::rsp_type      rsp
);
   import rbe_pkg::*;

   localparam int RSP_WIDTH = $bits(rsp_type);

   logic                  s1_valid_ff, s1_valid_in;
   desc_ctl_type          s1_ctl_ff;
   logic [COORD_BITS:0]   s1_x_ff;
   logic [31:0]           s1_prod_ff;
   logic [19:0]           factor;
   logic [31:0]           prod;
   logic                  s1_load;
   logic                  out_full;
   rsp_type               out_item;
   logic [RSP_WIDTH-1:0]  out_bits;

   assign factor      = (mid_ctl.region == REGION_HOST) ? cfg.host_pitch
                                                        : {4'h0, cfg.screen_width};
   assign prod        = 32'(mid_y) * 32'(factor);
   assign s1_load     = !s1_valid_ff || !out_full;
   assign mid_pop     = s1_load && !mid_empty;
   assign s1_valid_in = s1_load ? !mid_empty : s1_valid_ff;

   always_comb begin
      out_item.target_region = s1_ctl_ff.region;
      out_item.is_write      = s1_ctl_ff.is_write;
      out_item.write_data    = s1_ctl_ff.write_data;
      out_item.last_request  = s1_ctl_ff.last;
      if (s1_ctl_ff.region == REGION_HOST) begin
         out_item.byte_offset = s1_prod_ff + (32'(s1_x_ff) << 2);
      end else begin
         out_item.byte_offset = (s1_prod_ff + 32'(s1_x_ff)) << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         s1_ctl_ff  <= mid_ctl;
         s1_x_ff    <= mid_x;
         s1_prod_ff <= prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   rbe_queue #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (out_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_bits),
      .empty     (rsp_empty)
   );

   assign rsp = rsp_type'(out_bits);

endmodule

### hw/rtl/rect_blit_rgb565_engine_unit.sv
// ----------------------------------------------------------------------------
// rect_blit_rgb565_engine_unit
// Rectangle blit engine for an RGB565 frame buffer: fill, screen to host,
// host to screen and screen to screen, one memory request per issuing advance.
// ----------------------------------------------------------------------------
// Usage:
//  csr_*  : register writes, always ready; write only while no blit results
//           are outstanding.
//  req_*  : transactions (start, advance, read data). Accepted when req_push
//           is high and req_full is low; one transaction per cycle while req_full is low.
//  rsp_*  : memory requests, oldest first while rsp_empty is low; taken with
//           rsp_pop.
//  Path: a request from the advance that issues it passes through the
//  descriptor queue, multiply register and result queue to reach rsp_*.
//  Throughput: one transaction per cycle while req_full is low; the sequencer
//  updates its counters per transaction; address path: two-register pipeline.
//  Stall: when rsp_pop stays low the result queue, the multiply stage and the
//  descriptor queue fill, then req_full rises; nothing is dropped.
//  Reset: queues empty, engine idle, registers at reset values (screen
//  width 640).
// ----------------------------------------------------------------------------
module rect_blit_rgb565_engine_unit #(
   parameter int COORD_BITS  = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rbe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                        csr_data,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [1:0]                         req_operation,
   input  logic [31:0]                        req_read_data,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_target_region,
   output logic [31:0]                        rsp_byte_offset,
   output logic                               rsp_is_write,
   output logic [31:0]                        rsp_write_data,
   output logic                               rsp_last_request
);
   import rbe_pkg::*;

   localparam int CTL_WIDTH = $bits(desc_ctl_type);
   localparam int MID_WIDTH = CTL_WIDTH + 2 * (COORD_BITS + 1);

   cfg_type               cfg_ff, cfg_in;
   logic                  accept;
   logic                  desc_valid;
   desc_ctl_type          desc_ctl;
   logic [COORD_BITS:0]   desc_x, desc_y;
   logic                  mid_full, mid_empty, mid_pop;
   logic [MID_WIDTH-1:0]  mid_bits;
   desc_ctl_type          mid_ctl;
   logic [COORD_BITS:0]   mid_x, mid_y;
   rsp_type               rsp;

   assign csr_ready = 1'b1;
   assign req_full  = mid_full;
   assign accept    = req_push && !req_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLIT_MODE:     cfg_in.blit_mode     = csr_data[1:0];
            CSR_SOURCE_ORIGIN: cfg_in.source_origin = csr_data;
            CSR_DEST_ORIGIN:   cfg_in.dest_origin   = csr_data;
            CSR_EXTENT:        cfg_in.extent        = csr_data;
            CSR_HOST_PITCH:    cfg_in.host_pitch    = csr_data[19:0];
            CSR_FILL_COLOR:    cfg_in.fill_color    = csr_data;
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{blit_mode: MODE_FILL, source_origin: 32'h0, dest_origin: 32'h0,
                     extent: 32'h0, host_pitch: 20'h0, fill_color: 32'h0,
                     screen_width: SCREEN_WIDTH_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbe_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .operation  (req_operation),
      .read_data  (req_read_data),
      .desc_valid (desc_valid),
      .desc_ctl   (desc_ctl),
      .desc_x     (desc_x),
      .desc_y     (desc_y)
   );

   rbe_queue #(
      .WIDTH (MID_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_valid),
      .push_data ({desc_ctl, desc_x, desc_y}),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_bits),
      .empty     (mid_empty)
   );

   assign mid_ctl = desc_ctl_type'(mid_bits[MID_WIDTH-1 -: CTL_WIDTH]);
   assign mid_x   = mid_bits[2*COORD_BITS+1 -: COORD_BITS+1];
   assign mid_y   = mid_bits[COORD_BITS:0];

   rbe_back #(
      .COORD_BITS  (COORD_BITS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_ctl   (mid_ctl),
      .mid_x     (mid_x),
      .mid_y     (mid_y),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_target_region = rsp.target_region;
   assign rsp_byte_offset   = rsp.byte_offset;
   assign rsp_is_write      = rsp.is_write;
   assign rsp_write_data    = rsp.write_data;
   assign rsp_last_request  = rsp.last_request;

`ifndef SYNTH
   last_on_write: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_request |-> rsp_is_write)
      else $error("last flag on a read request");

   read_has_no_data: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_is_write |-> rsp_write_data == 32'h0)
      else $error("read request carries write data");

   stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_byte_offset))
      else $error("pending request changed while stalled");
`endif

endmodule
